>>> hw/rtl/sg3_pkg.sv
// Shared types, constants and helpers for the 3x3 Sobel gradient core.
package sg3_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned RAW_W       = 11;
  localparam int unsigned SUM_W       = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRADIENT_AXIS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [DIM_W-1:0]      DIM_MIN          = 13'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic AXIS_X   = 1'b0;

  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_LEVEL_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic col0;
    logic col1;
    logic emit;
    logic last;
    logic top;
    logic bot;
  } sg3_flags_t;

  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] pix;
    logic                       axis;
    logic                       last;
  } sg3_entry_t;

  typedef struct packed {
    logic                    empty;
    logic [FIFO_LEVEL_W-1:0] level;
  } sg3_fifo_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    if (x < DIM_MIN) begin
      x = DIM_MIN;
    end else if (x > hi) begin
      x = hi;
    end
    return x;
  endfunction

  function automatic logic signed [SUM_W-1:0] ext_pix(input logic [PIX_W-1:0] v);
    return $signed({{(SUM_W - PIX_W){1'b0}}, v});
  endfunction

endpackage

>>> hw/rtl/sg3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sg3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sg3_fifo.sv
// Short request queue between the window front end and the arithmetic back end.
module sg3_fifo import sg3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sg3_entry_t       push_data_i,
  input  logic             pop_i,
  output sg3_entry_t       head_o,
  output sg3_fifo_status_t status_o
);

  sg3_entry_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_LEVEL_W-1:0] level_q, level_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.level = level_q;
  assign status_o.empty = (level_q == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q != FIFO_LEVEL_W'(FIFO_DEPTH)))
    else $error("Request pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (level_q != '0))
    else $error("Request popped from an empty queue.");

  a_level_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (level_q == $past(level_q) + 1'b1))
    else $error("Queue level did not follow a push.");

  a_level_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (level_q == $past(level_q) - 1'b1))
    else $error("Queue level did not follow a pop.");
`endif

endmodule

>>> hw/rtl/sg3_front.sv
// Front end: configuration, frame position tracking, line stores and the 3x3 window.
module sg3_front import sg3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [PIX_W-1:0]       pixel_i,
  input  sg3_fifo_status_t       fifo_status_i,
  output logic                   push_o,
  output sg3_entry_t             push_data_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  localparam logic [WW-1:0] WIDTH_RST  = WW'(clamp_dim(FRAME_WIDTH_RST, DIM_W'(MAX_WIDTH)));
  localparam logic [HW-1:0] HEIGHT_RST = HW'(clamp_dim(FRAME_HEIGHT_RST, DIM_W'(MAX_HEIGHT)));

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic          axis_q, axis_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic             s1_valid_q;
  logic [CW-1:0]    s1_col_q;
  logic [PIX_W-1:0] s1_val_q;
  sg3_flags_t       s1_flags_q;

  logic [2:0][2:0][PIX_W-1:0] win_q, win_d;
  logic [2:0][2:0][PIX_W-1:0] snap;
  logic [2:0][PIX_W-1:0]      new_col;

  logic             in_acc;
  logic             dim_write;
  logic             col_last;
  logic [RW-1:0]    h_row;
  sg3_flags_t       flags;
  logic [PIX_W-1:0] val;
  logic [PIX_W-1:0] up_rdata, mid_rdata;

  assign in_stall_o = ((FIFO_LEVEL_W + 1)'(fifo_status_i.level) +
                       (FIFO_LEVEL_W + 1)'(s1_valid_q)) >=
                      (FIFO_LEVEL_W + 1)'(FIFO_DEPTH);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign dim_write  = cfg_we_i &&
                      (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);

  assign h_row    = RW'(height_q);
  assign col_last = (WW'(col_q) + WW'(1)) == width_q;

  always_comb begin
    flags.col0 = (col_q == '0);
    flags.col1 = (col_q == CW'(1));
    flags.emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && !flags.col0);
    flags.last = (row_q == h_row + RW'(1)) && flags.col0;
    flags.top  = flags.col0 ? (row_q <= RW'(2)) : (row_q == RW'(1));
    flags.bot  = flags.col0 ? (row_q == h_row + RW'(1)) : (row_q == h_row);
    val        = ((op_i == OP_PIXEL) && (row_q < h_row)) ? pixel_i : '0;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    axis_d   = axis_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:   width_d  = WW'(clamp_dim(cfg_data_i, DIM_W'(MAX_WIDTH)));
        CFG_FRAME_HEIGHT:  height_d = HW'(clamp_dim(cfg_data_i, DIM_W'(MAX_HEIGHT)));
        CFG_GRADIENT_AXIS: axis_d   = cfg_data_i[0];
        default:           axis_d   = axis_q;
      endcase
    end
    if (dim_write) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (flags.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      axis_q     <= AXIS_X;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      axis_q     <= axis_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= col_q;
      s1_val_q   <= val;
      s1_flags_q <= flags;
    end
    win_q <= win_d;
  end

  sg3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_upper_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(mid_rdata),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(up_rdata)
  );

  sg3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_middle_ram (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(s1_val_q),
    .re_i   (in_acc),
    .raddr_i(col_q),
    .rdata_o(mid_rdata)
  );

  assign new_col[0] = up_rdata;
  assign new_col[1] = mid_rdata;
  assign new_col[2] = s1_val_q;

  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      snap[r][0] = s1_flags_q.col1 ? '0 : win_q[r][1];
      snap[r][1] = win_q[r][2];
      snap[r][2] = s1_flags_q.col0 ? '0 : new_col[r];
      if (s1_valid_q) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
        win_d[r][2] = new_col[r];
      end
    end
    if (s1_flags_q.top) begin
      snap[0] = '0;
    end
    if (s1_flags_q.bot) begin
      snap[2] = '0;
    end
  end

  assign push_o           = s1_valid_q && s1_flags_q.emit;
  assign push_data_o.pix  = snap;
  assign push_data_o.axis = axis_q;
  assign push_data_o.last = s1_flags_q.last;

endmodule

>>> hw/rtl/sg3_back.sv
// Back end: kernel sum of a queued window and the output register.
module sg3_back import sg3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sg3_fifo_status_t        fifo_status_i,
  input  sg3_entry_t              head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RAW_W-1:0] gradient_raw_o,
  output logic [PIX_W-1:0]        gradient_byte_o,
  output logic                    last_in_frame_o
);

  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] sum;
  logic signed [RAW_W-1:0] raw_q;
  logic                    last_q;

  always_comb begin
    if (head_i.axis == AXIS_X) begin
      sum = (ext_pix(head_i.pix[0][2]) - ext_pix(head_i.pix[0][0]))
          + ((ext_pix(head_i.pix[1][2]) - ext_pix(head_i.pix[1][0])) <<< 1)
          + (ext_pix(head_i.pix[2][2]) - ext_pix(head_i.pix[2][0]));
    end else begin
      sum = (ext_pix(head_i.pix[2][0]) + (ext_pix(head_i.pix[2][1]) <<< 1)
          + ext_pix(head_i.pix[2][2]))
          - (ext_pix(head_i.pix[0][0]) + (ext_pix(head_i.pix[0][1]) <<< 1)
          + ext_pix(head_i.pix[0][2]));
    end
  end

  assign pop_o = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      raw_q  <= sum[RAW_W-1:0];
      last_q <= head_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gradient_raw_o  = raw_q;
  assign gradient_byte_o = raw_q[PIX_W-1:0];
  assign last_in_frame_o = last_q;

endmodule

>>> hw/rtl/sobel_gradient_3x3_core.sv
// Top level of the streaming 3x3 Sobel gradient core.
//
// Pixels enter in raster order on the input channel (in_valid_i, in_stall_o, op_i,
// pixel_i); a request is taken at a clock edge with valid high and stall low. After
// the pixels of a frame, frame_width+1 flush requests (op_i high) push out the last
// gradients. Results leave on the output channel (out_valid_o, out_stall_i) in raster
// order, one per image pixel, with last_in_frame_o on the final one of the frame.
// The core takes one request per clock while in_stall_o is low. The request that
// completes a window comes frame_width+1 requests after its centre pixel. Between that
// request and the result lie the registered line-store read that forms the window, the
// queue write and the output register.
// When the receiver stalls, the result holds in the output register and a four-entry
// queue fills; the input stalls once the queue, counting a request still on its way, is full.
// Reset restores width 640, height 480 and the horizontal kernel, and puts the core at
// the start of a frame. Writing the width or height also restarts the frame. Registers
// may be written only while no request is in flight.
module sobel_gradient_3x3_core import sg3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic [PIX_W-1:0]        pixel_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RAW_W-1:0] gradient_raw_o,
  output logic [PIX_W-1:0]        gradient_byte_o,
  output logic                    last_in_frame_o
);

  logic             push;
  sg3_entry_t       push_data;
  logic             pop;
  sg3_entry_t       head;
  sg3_fifo_status_t fifo_status;

  sg3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .pixel_i      (pixel_i),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  sg3_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (fifo_status)
  );

  sg3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_status_i  (fifo_status),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gradient_raw_o (gradient_raw_o),
    .gradient_byte_o(gradient_byte_o),
    .last_in_frame_o(last_in_frame_o)
  );

endmodule
